>>> design/vcdwd_pkg.sv
// Shared types, codes and defaults of the VCDIFF window decoder.
package vcdwd_pkg;

    localparam int ADDR_W = 13;
    localparam int BANK_SIZE = 256;

    localparam int DEF_TARGET_DEPTH = 4096;
    localparam int DEF_SOURCE_DEPTH = 4096;
    localparam int DEF_NEAR_SLOTS = 4;
    localparam int DEF_SAME_ENTRIES = 768;

    // Commands
    localparam logic [2:0] CMD_START = 3'd0;
    localparam logic [2:0] CMD_LOAD = 3'd1;
    localparam logic [2:0] CMD_ADD = 3'd2;
    localparam logic [2:0] CMD_RUN = 3'd3;
    localparam logic [2:0] CMD_COPY = 3'd4;
    localparam logic [2:0] CMD_READ = 3'd5;

    // Status codes
    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_NO_SOURCE = 3'd1;
    localparam logic [2:0] ST_UNWRITTEN = 3'd2;
    localparam logic [2:0] ST_OVERFLOW = 3'd3;
    localparam logic [2:0] ST_BAD_MODE = 3'd4;

    // Address modes
    localparam logic [3:0] MODE_SELF = 4'd0;
    localparam logic [3:0] MODE_HERE = 4'd1;
    localparam int MODE_NEAR0 = 2;

    // Configuration register indexes
    localparam logic REG_SOURCE_LENGTH = 1'b0;
    localparam logic REG_TARGET_LENGTH = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE, S_RUN, S_DECODE, S_CPY_RD, S_CPY_WR, S_READ
    } t_top_state;

    typedef enum logic [2:0] {
        C_CLEAR, C_IDLE, C_SAME, C_REDUCE, C_WRITE, C_BAD
    } t_cache_state;

    typedef struct packed {
        logic              start;
        logic              clear;
        logic [3:0]        mode;
        logic [ADDR_W-1:0] operand;
        logic [ADDR_W-1:0] here;
    } t_cache_req;

    typedef struct packed {
        logic              ready;
        logic              done;
        logic              bad;
        logic [ADDR_W-1:0] addr;
    } t_cache_rsp;

endpackage

>>> design/vcdwd_addr_cache.sv
// Address cache: near slots, same cache memory with clearing sweep, copy address decode.
module vcdwd_addr_cache #(
    parameter int NEAR_SLOTS = vcdwd_pkg::DEF_NEAR_SLOTS,
    parameter int SAME_ENTRIES = vcdwd_pkg::DEF_SAME_ENTRIES
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  vcdwd_pkg::t_cache_req i_req,
    output vcdwd_pkg::t_cache_rsp o_rsp
);

    localparam int AW = vcdwd_pkg::ADDR_W;
    localparam int SAME_BANKS = SAME_ENTRIES / vcdwd_pkg::BANK_SIZE;
    localparam int SIW = $clog2(SAME_ENTRIES);
    localparam int NPW = (NEAR_SLOTS > 1) ? $clog2(NEAR_SLOTS) : 1;
    // SAME_ENTRIES is at least 256, so five shifted subtracts bring any address below it
    localparam int RED_STEPS = 5;
    localparam int RW = AW + 4;

    vcdwd_pkg::t_cache_state r_state, n_state;
    logic [AW-1:0]  r_near [NEAR_SLOTS];
    logic [NPW-1:0] r_ptr, n_ptr;
    logic [AW-1:0]  r_addr, n_addr;
    logic [AW-1:0]  r_rem, n_rem;
    logic [2:0]     r_step, n_step;
    logic [SIW-1:0] r_clr_idx, n_clr_idx;
    logic [AW-1:0]  same_mem [SAME_ENTRIES];
    logic [AW-1:0]  r_rdata;

    logic           mem_we;
    logic [SIW-1:0] mem_waddr;
    logic [AW-1:0]  mem_wdata;
    logic [SIW-1:0] mem_raddr;
    logic           near_clr, near_upd;
    logic [AW-1:0]  upd_val;

    int             mode_i, idx_i;
    logic           is_near, is_same, idx_ok;
    logic [AW-1:0]  direct_addr;
    logic [RW-1:0]  sub_val;

    // Mode classification and direct address forms
    always_comb begin
        mode_i = int'(i_req.mode);
        is_near = (mode_i >= vcdwd_pkg::MODE_NEAR0) &&
                  (mode_i < vcdwd_pkg::MODE_NEAR0 + NEAR_SLOTS);
        is_same = (mode_i >= vcdwd_pkg::MODE_NEAR0 + NEAR_SLOTS) &&
                  (mode_i < vcdwd_pkg::MODE_NEAR0 + NEAR_SLOTS + SAME_BANKS);
        idx_i = ((mode_i - vcdwd_pkg::MODE_NEAR0 - NEAR_SLOTS) * vcdwd_pkg::BANK_SIZE)
                + int'(i_req.operand[7:0]);
        idx_ok = (idx_i >= 0) && (idx_i < SAME_ENTRIES);
        if (i_req.mode == vcdwd_pkg::MODE_SELF) begin
            direct_addr = i_req.operand;
        end else if (i_req.mode == vcdwd_pkg::MODE_HERE) begin
            direct_addr = i_req.here - i_req.operand;
        end else begin
            direct_addr = r_near[NPW'(i_req.mode - 4'(vcdwd_pkg::MODE_NEAR0))] + i_req.operand;
        end
        sub_val = RW'(SAME_ENTRIES) << (3'(RED_STEPS - 1) - r_step);
    end

    // Sequencer: clear sweep, same read, modulo reduction, same write, bad mode report
    always_comb begin
        n_state = r_state;
        n_ptr = r_ptr;
        n_addr = r_addr;
        n_rem = r_rem;
        n_step = r_step;
        n_clr_idx = r_clr_idx;
        mem_we = 1'b0;
        mem_waddr = r_clr_idx;
        mem_wdata = '0;
        mem_raddr = SIW'(idx_i);
        near_clr = 1'b0;
        near_upd = 1'b0;
        upd_val = direct_addr;
        o_rsp.ready = (r_state == vcdwd_pkg::C_IDLE);
        o_rsp.done = 1'b0;
        o_rsp.bad = 1'b0;
        o_rsp.addr = r_addr;
        case (r_state)
            vcdwd_pkg::C_CLEAR: begin
                mem_we = 1'b1;
                if (r_clr_idx == SIW'(SAME_ENTRIES - 1)) begin
                    n_clr_idx = '0;
                    n_state = vcdwd_pkg::C_IDLE;
                end else begin
                    n_clr_idx = r_clr_idx + 1'b1;
                end
            end
            vcdwd_pkg::C_IDLE: begin
                if (i_req.clear) begin
                    near_clr = 1'b1;
                    n_ptr = '0;
                    n_clr_idx = '0;
                    n_state = vcdwd_pkg::C_CLEAR;
                end else if (i_req.start) begin
                    if (i_req.mode == vcdwd_pkg::MODE_SELF ||
                        i_req.mode == vcdwd_pkg::MODE_HERE || is_near) begin
                        near_upd = 1'b1;
                        n_addr = direct_addr;
                        n_rem = direct_addr;
                        n_step = '0;
                        n_state = vcdwd_pkg::C_REDUCE;
                    end else if (is_same && idx_ok) begin
                        n_state = vcdwd_pkg::C_SAME;
                    end else begin
                        n_state = vcdwd_pkg::C_BAD;
                    end
                end
            end
            vcdwd_pkg::C_SAME: begin
                near_upd = 1'b1;
                upd_val = r_rdata;
                n_addr = r_rdata;
                n_rem = r_rdata;
                n_step = '0;
                n_state = vcdwd_pkg::C_REDUCE;
            end
            vcdwd_pkg::C_REDUCE: begin
                if ({4'b0, r_rem} >= sub_val) begin
                    n_rem = AW'({4'b0, r_rem} - sub_val);
                end
                if (r_step == 3'(RED_STEPS - 1)) begin
                    n_state = vcdwd_pkg::C_WRITE;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            vcdwd_pkg::C_WRITE: begin
                mem_we = 1'b1;
                mem_waddr = SIW'(r_rem);
                mem_wdata = r_addr;
                o_rsp.done = 1'b1;
                n_state = vcdwd_pkg::C_IDLE;
            end
            // Unknown mode: caches untouched, report in the cycle after the request
            vcdwd_pkg::C_BAD: begin
                o_rsp.done = 1'b1;
                o_rsp.bad = 1'b1;
                n_state = vcdwd_pkg::C_IDLE;
            end
            default: n_state = vcdwd_pkg::C_IDLE;
        endcase
        if (near_upd) begin
            n_ptr = (r_ptr == NPW'(NEAR_SLOTS - 1)) ? '0 : r_ptr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= vcdwd_pkg::C_CLEAR;
            r_ptr <= '0;
            r_clr_idx <= '0;
            r_step <= '0;
        end else begin
            r_state <= n_state;
            r_ptr <= n_ptr;
            r_clr_idx <= n_clr_idx;
            r_step <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr <= n_addr;
        r_rem <= n_rem;
    end

    // Near slots
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NEAR_SLOTS; k++) begin
            if (!i_rst_n || near_clr) begin
                r_near[k] <= '0;
            end else if (near_upd && r_ptr == NPW'(k)) begin
                r_near[k] <= upd_val;
            end
        end
    end

    // Same cache memory
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            same_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= same_mem[mem_raddr];
    end

    a_sweep_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == vcdwd_pkg::C_CLEAR |-> !o_rsp.ready)
        else $error("ready during clear sweep");
    a_clear_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == vcdwd_pkg::C_IDLE && i_req.clear) |=>
        (r_state == vcdwd_pkg::C_CLEAR && r_clr_idx == '0))
        else $error("clear did not start sweep");
    a_done_bad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.bad |-> o_rsp.done)
        else $error("bad without done");
    a_reduce_to_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == vcdwd_pkg::C_WRITE |-> int'(r_rem) < SAME_ENTRIES)
        else $error("same index out of range");

endmodule

>>> design/vcdiff_window_decoder.sv
// Top level of the VCDIFF window decoder: command sequencer, source and target stores.
//
// Usage: configuration registers (source_length index 0, target_length index 1) are written
// through i_cfg_wr_en / i_cfg_index / i_cfg_wdata while the block is idle. Commands arrive on
// the s_axis channel (command in tuser); each produces exactly one result transfer on m_axis.
// One command is worked on at a time. Steps per command, from accept to result:
//   load source, start window, unknown command: result registered on accept;
//   read target: the registered target store read, then the result register;
//   add literal / run: one byte per cycle into the target store, then the result;
//   copy: address decode in the cache (for a same cache address first a memory
//   read), a five-step modulo reduction and write back, then a read and a
//   write per byte so overlapping copies repeat bytes; a copy stopped by an address
//   error, or a bad address mode, answers right after the decode.
// Start window triggers a sweep of the same cache over all SAME_ENTRIES entries (768 by
// default), and reset runs the same sweep; s_axis_tready is low meanwhile.
// The result sits in an output register; the next command is accepted while the result
// is taken in the same cycle, and s_axis_tready stays low while m_axis stalls.
// Reset is synchronous, active low; it clears caches, position and registers; store
// contents are undefined until written.
module vcdiff_window_decoder #(
    parameter int TARGET_DEPTH = vcdwd_pkg::DEF_TARGET_DEPTH,
    parameter int SOURCE_DEPTH = vcdwd_pkg::DEF_SOURCE_DEPTH,
    parameter int NEAR_SLOTS = vcdwd_pkg::DEF_NEAR_SLOTS,
    parameter int SAME_ENTRIES = vcdwd_pkg::DEF_SAME_ENTRIES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_index,
    input  logic [12:0] i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // command[2:0]
    input  logic [2:0]  s_axis_tuser,
    // position[11:0], data_byte[19:12], span_size[32:20],
    // addr_mode[36:33], addr_operand[49:37], zero fill[55:50]
    input  logic [55:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // read_data[7:0], decoded_address[20:8], target_fill[33:21], status[36:34],
    // zero fill[39:37]
    output logic [39:0] m_axis_tdata
);

    localparam int AW = vcdwd_pkg::ADDR_W;
    localparam int TW = $clog2(TARGET_DEPTH);
    localparam int SW = $clog2(SOURCE_DEPTH);
    localparam int TD_CAP = (TARGET_DEPTH < 8192) ? TARGET_DEPTH : 8192;
    localparam int SD_CAP = (SOURCE_DEPTH < 8192) ? SOURCE_DEPTH : 8192;

    // Input fields
    logic [2:0]    in_cmd;
    logic [11:0]   in_pos;
    logic [7:0]    in_data;
    logic [12:0]   in_span;
    logic [3:0]    in_mode;
    logic [AW-1:0] in_oper;
    assign in_cmd = s_axis_tuser;
    assign in_pos = s_axis_tdata[11:0];
    assign in_data = s_axis_tdata[19:12];
    assign in_span = s_axis_tdata[32:20];
    assign in_mode = s_axis_tdata[36:33];
    assign in_oper = s_axis_tdata[49:37];

    vcdwd_pkg::t_top_state r_state, n_state;
    logic [AW-1:0] r_slen, r_tlen;
    logic [AW-1:0] r_tpos, n_tpos;
    logic [7:0]    r_data, n_data;
    logic [12:0]   r_cnt, n_cnt;
    logic [13:0]   r_cur, n_cur;
    logic          r_from_src, n_from_src;
    logic          r_rd_ok, n_rd_ok;
    logic          r_ovalid, n_ovalid;
    logic [7:0]    r_o_rd, n_o_rd;
    logic [AW-1:0] r_o_addr, n_o_addr;
    logic [2:0]    r_o_status, n_o_status;

    logic [7:0]    tgt_mem [TARGET_DEPTH];
    logic [7:0]    src_mem [SOURCE_DEPTH];
    logic [7:0]    r_tgt_rdata, r_src_rdata;
    logic          tgt_we, src_we;
    logic [TW-1:0] tgt_waddr, tgt_raddr;
    logic [7:0]    tgt_wdata;
    logic [SW-1:0] src_waddr, src_raddr;

    vcdwd_pkg::t_cache_req cache_req;
    vcdwd_pkg::t_cache_rsp cache_rsp;

    logic          accept;
    logic [13:0]   limit;
    logic          full;
    logic [13:0]   span_end, src_end;
    logic [13:0]   slen14;

    assign slen14 = {1'b0, r_slen};
    assign limit = ({1'b0, r_tlen} < 14'(TD_CAP)) ? {1'b0, r_tlen} : 14'(TD_CAP);
    assign full = ({1'b0, r_tpos} >= limit);
    assign span_end = {1'b0, cache_rsp.addr} + {1'b0, r_cnt};
    assign src_end = (span_end > slen14) ? slen14 : span_end;

    assign s_axis_tready = (r_state == vcdwd_pkg::S_IDLE) && cache_rsp.ready &&
                           (!r_ovalid || m_axis_tready);
    assign accept = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_ovalid;
    // target position holds still while a result waits, so it is the fill of that result
    assign m_axis_tdata = {3'b0, r_o_status, r_tpos, r_o_addr, r_o_rd};

    vcdwd_addr_cache #(
        .NEAR_SLOTS  (NEAR_SLOTS),
        .SAME_ENTRIES(SAME_ENTRIES)
    ) u_cache (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (cache_req),
        .o_rsp  (cache_rsp)
    );

    // Command sequencer
    always_comb begin
        n_state = r_state;
        n_tpos = r_tpos;
        n_data = r_data;
        n_cnt = r_cnt;
        n_cur = r_cur;
        n_from_src = r_from_src;
        n_rd_ok = r_rd_ok;
        n_ovalid = r_ovalid && !m_axis_tready;
        n_o_rd = r_o_rd;
        n_o_addr = r_o_addr;
        n_o_status = r_o_status;
        tgt_we = 1'b0;
        tgt_waddr = TW'(r_tpos);
        tgt_wdata = r_data;
        tgt_raddr = TW'(in_pos);
        src_we = 1'b0;
        src_waddr = SW'(in_pos);
        src_raddr = SW'(r_cur);
        cache_req.start = 1'b0;
        cache_req.clear = 1'b0;
        cache_req.mode = in_mode;
        cache_req.operand = in_oper;
        cache_req.here = r_slen + r_tpos;
        case (r_state)
            vcdwd_pkg::S_IDLE: begin
                if (accept) begin
                    n_data = in_data;
                    n_cnt = in_span;
                    n_o_rd = '0;
                    n_o_addr = '0;
                    n_o_status = vcdwd_pkg::ST_OK;
                    case (in_cmd)
                        vcdwd_pkg::CMD_START: begin
                            cache_req.clear = 1'b1;
                            n_tpos = '0;
                            n_ovalid = 1'b1;
                        end
                        vcdwd_pkg::CMD_LOAD: begin
                            src_we = ({2'b0, in_pos} < 14'(SD_CAP));
                            n_ovalid = 1'b1;
                        end
                        vcdwd_pkg::CMD_ADD: begin
                            n_cnt = 13'd1;
                            n_state = vcdwd_pkg::S_RUN;
                        end
                        vcdwd_pkg::CMD_RUN: n_state = vcdwd_pkg::S_RUN;
                        vcdwd_pkg::CMD_COPY: begin
                            cache_req.start = 1'b1;
                            n_state = vcdwd_pkg::S_DECODE;
                        end
                        vcdwd_pkg::CMD_READ: begin
                            n_rd_ok = ({2'b0, in_pos} < 14'(TD_CAP));
                            n_state = vcdwd_pkg::S_READ;
                        end
                        default: begin
                            n_o_status = vcdwd_pkg::ST_BAD_MODE;
                            n_ovalid = 1'b1;
                        end
                    endcase
                end
            end
            vcdwd_pkg::S_RUN: begin
                if (r_cnt == '0) begin
                    n_ovalid = 1'b1;
                    n_state = vcdwd_pkg::S_IDLE;
                end else if (full) begin
                    n_o_status = vcdwd_pkg::ST_OVERFLOW;
                    n_ovalid = 1'b1;
                    n_state = vcdwd_pkg::S_IDLE;
                end else begin
                    tgt_we = 1'b1;
                    n_tpos = r_tpos + 1'b1;
                    n_cnt = r_cnt - 1'b1;
                end
            end
            vcdwd_pkg::S_DECODE: begin
                if (cache_rsp.done) begin
                    n_cur = {1'b0, cache_rsp.addr};
                    n_o_addr = cache_rsp.addr;
                    n_state = vcdwd_pkg::S_IDLE;
                    n_ovalid = 1'b1;
                    if (cache_rsp.bad) begin
                        n_o_addr = '0;
                        n_o_status = vcdwd_pkg::ST_BAD_MODE;
                    end else if (cache_rsp.addr < r_slen) begin
                        if (r_cnt != '0 && src_end > 14'(SD_CAP)) begin
                            n_o_status = vcdwd_pkg::ST_NO_SOURCE;
                        end else begin
                            n_ovalid = 1'b0;
                            n_state = vcdwd_pkg::S_CPY_RD;
                        end
                    end else if ((cache_rsp.addr - r_slen) >= r_tpos) begin
                        n_o_status = vcdwd_pkg::ST_UNWRITTEN;
                    end else begin
                        n_ovalid = 1'b0;
                        n_state = vcdwd_pkg::S_CPY_RD;
                    end
                end
            end
            vcdwd_pkg::S_CPY_RD: begin
                tgt_raddr = TW'(r_cur - slen14);
                n_from_src = (r_cur < slen14);
                if (r_cnt == '0) begin
                    n_ovalid = 1'b1;
                    n_state = vcdwd_pkg::S_IDLE;
                end else if (full) begin
                    n_o_status = vcdwd_pkg::ST_OVERFLOW;
                    n_ovalid = 1'b1;
                    n_state = vcdwd_pkg::S_IDLE;
                end else begin
                    n_state = vcdwd_pkg::S_CPY_WR;
                end
            end
            vcdwd_pkg::S_CPY_WR: begin
                tgt_we = 1'b1;
                tgt_wdata = r_from_src ? r_src_rdata : r_tgt_rdata;
                n_tpos = r_tpos + 1'b1;
                n_cur = r_cur + 1'b1;
                n_cnt = r_cnt - 1'b1;
                n_state = vcdwd_pkg::S_CPY_RD;
            end
            vcdwd_pkg::S_READ: begin
                n_o_rd = r_rd_ok ? r_tgt_rdata : '0;
                n_ovalid = 1'b1;
                n_state = vcdwd_pkg::S_IDLE;
            end
            default: n_state = vcdwd_pkg::S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= vcdwd_pkg::S_IDLE;
            r_tpos <= '0;
            r_ovalid <= 1'b0;
            r_slen <= '0;
            r_tlen <= '0;
        end else begin
            r_state <= n_state;
            r_tpos <= n_tpos;
            r_ovalid <= n_ovalid;
            if (i_cfg_wr_en && i_cfg_index == vcdwd_pkg::REG_SOURCE_LENGTH) begin
                r_slen <= i_cfg_wdata;
            end
            if (i_cfg_wr_en && i_cfg_index == vcdwd_pkg::REG_TARGET_LENGTH) begin
                r_tlen <= i_cfg_wdata;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        r_cnt <= n_cnt;
        r_cur <= n_cur;
        r_from_src <= n_from_src;
        r_rd_ok <= n_rd_ok;
        r_o_rd <= n_o_rd;
        r_o_addr <= n_o_addr;
        r_o_status <= n_o_status;
    end

    // Target store
    always_ff @(posedge i_clk) begin
        if (tgt_we) begin
            tgt_mem[tgt_waddr] <= tgt_wdata;
        end
        r_tgt_rdata <= tgt_mem[tgt_raddr];
    end

    // Source store
    always_ff @(posedge i_clk) begin
        if (src_we) begin
            src_mem[src_waddr] <= in_data;
        end
        r_src_rdata <= src_mem[src_raddr];
    end

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> (r_state == vcdwd_pkg::S_IDLE && cache_rsp.ready))
        else $error("ready outside idle");
    a_start_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && in_cmd == vcdwd_pkg::CMD_START) |=> (r_tpos == '0 && !cache_rsp.ready))
        else $error("start window did not clear");
    a_tpos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_tpos} <= 14'(TD_CAP))
        else $error("target position beyond store");
    a_write_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tgt_we |-> !full)
        else $error("target write past limit");

endmodule

>>> tb/tb_vcdiff_window_decoder.sv
// Self-checking testbench of the VCDIFF window decoder: random command streams, scoreboard.
module tb_vcdiff_window_decoder;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TGT_DEPTH = vcdwd_pkg::DEF_TARGET_DEPTH;
    localparam int SRC_DEPTH = vcdwd_pkg::DEF_SOURCE_DEPTH;
    localparam int NEAR_N = vcdwd_pkg::DEF_NEAR_SLOTS;
    localparam int SAME_N = vcdwd_pkg::DEF_SAME_ENTRIES;
    localparam int SAME_MODE0 = vcdwd_pkg::MODE_NEAR0 + NEAR_N;
    localparam int STALL_LIMIT = 30000;

    typedef struct packed {
        logic [12:0] operand;
        logic [3:0]  mode;
        logic [12:0] span;
        logic [7:0]  data;
        logic [11:0] pos;
        logic [2:0]  cmd;
    } t_cmd;

    typedef struct packed {
        logic [2:0]  status;
        logic [12:0] fill;
        logic [12:0] addr;
        logic [7:0]  rd;
    } t_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_wr_en = 1'b0;
    logic        i_cfg_index = 1'b0;
    logic [12:0] i_cfg_wdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [2:0]  s_axis_tuser = '0;
    logic [55:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;

    vcdiff_window_decoder i_dut (.*);

    always #2 i_clk = ~i_clk;

    // Predictor state
    logic [7:0]  tgt_mem [TGT_DEPTH];
    logic [7:0]  src_mem [SRC_DEPTH];
    bit          tgt_wr [TGT_DEPTH];
    bit          src_wr [SRC_DEPTH];
    logic [12:0] near_addr [NEAR_N];
    int          near_ptr;
    logic [12:0] same_addr [SAME_N];
    int          fill_pos;
    int          src_len;
    int          tgt_len;

    t_cmd    cmd_q [$];
    t_result result_q [$];
    int      errors = 0;
    int      n_items = 0;
    int      st_seen [8];
    bit      s_fire = 1'b0;

    // Address decode without touching the caches
    function automatic void peek_addr(input logic [3:0] mode, input logic [12:0] opnd,
                                      output logic [12:0] a, output bit bad);
        int m;
        m = mode;
        bad = 1'b0;
        a = '0;
        if (mode == vcdwd_pkg::MODE_SELF) a = opnd;
        else if (mode == vcdwd_pkg::MODE_HERE) a = 13'(src_len + fill_pos) - opnd;
        else if (m < SAME_MODE0) a = near_addr[m - vcdwd_pkg::MODE_NEAR0] + opnd;
        else if (m < SAME_MODE0 + SAME_N / vcdwd_pkg::BANK_SIZE)
            a = same_addr[((m - SAME_MODE0) << 8) + opnd[7:0]];
        else bad = 1'b1;
    endfunction

    // Works out the result of one command and advances the predictor state
    function automatic t_result run_command(t_cmd c);
        t_result r;
        int lim, n, a, e;
        logic [12:0] ad;
        logic [7:0] b;
        bit bad;
        r = '0;
        lim = tgt_len < TGT_DEPTH ? tgt_len : TGT_DEPTH;
        r.status = vcdwd_pkg::ST_OK;
        case (c.cmd)
            vcdwd_pkg::CMD_START: begin
                foreach (near_addr[i]) near_addr[i] = '0;
                foreach (same_addr[i]) same_addr[i] = '0;
                near_ptr = 0;
                fill_pos = 0;
            end
            vcdwd_pkg::CMD_LOAD: begin
                src_mem[c.pos] = c.data;
                src_wr[c.pos] = 1'b1;
            end
            vcdwd_pkg::CMD_ADD, vcdwd_pkg::CMD_RUN: begin
                n = (c.cmd == vcdwd_pkg::CMD_ADD) ? 1 : c.span;
                for (int i = 0; i < n; i++) begin
                    if (fill_pos >= lim) begin
                        r.status = vcdwd_pkg::ST_OVERFLOW;
                        break;
                    end
                    tgt_mem[fill_pos] = c.data;
                    tgt_wr[fill_pos] = 1'b1;
                    fill_pos++;
                end
            end
            vcdwd_pkg::CMD_COPY: begin
                peek_addr(c.mode, c.operand, ad, bad);
                if (bad) begin
                    r.status = vcdwd_pkg::ST_BAD_MODE;
                end else begin
                    near_addr[near_ptr] = ad;
                    near_ptr = (near_ptr + 1) % NEAR_N;
                    same_addr[ad % SAME_N] = ad;
                    r.addr = ad;
                    if (ad < src_len) begin
                        e = ad + c.span;
                        if (e > src_len) e = src_len;
                        if (c.span != 0 && e > SRC_DEPTH) r.status = vcdwd_pkg::ST_NO_SOURCE;
                    end else if (ad - src_len >= fill_pos) begin
                        r.status = vcdwd_pkg::ST_UNWRITTEN;
                    end
                    if (r.status == vcdwd_pkg::ST_OK) begin
                        for (int i = 0; i < c.span; i++) begin
                            a = ad + i;
                            b = '0;
                            if (fill_pos >= lim) begin
                                r.status = vcdwd_pkg::ST_OVERFLOW;
                                break;
                            end
                            if (a < src_len) begin
                                if (a < SRC_DEPTH) b = src_mem[a];
                            end else if (a - src_len < TGT_DEPTH) begin
                                b = tgt_mem[a - src_len];
                            end
                            tgt_mem[fill_pos] = b;
                            tgt_wr[fill_pos] = 1'b1;
                            fill_pos++;
                        end
                    end
                end
            end
            vcdwd_pkg::CMD_READ: r.rd = tgt_mem[c.pos];
            default: r.status = vcdwd_pkg::ST_BAD_MODE;
        endcase
        r.fill = 13'(fill_pos);
        return r;
    endfunction

    // True when the command never reads a store entry that was never written
    function automatic bit reads_written(t_cmd c);
        logic [12:0] ad;
        bit bad;
        int e;
        if (c.cmd == vcdwd_pkg::CMD_READ) return tgt_wr[c.pos];
        if (c.cmd != vcdwd_pkg::CMD_COPY) return 1'b1;
        peek_addr(c.mode, c.operand, ad, bad);
        if (bad || ad >= src_len) return 1'b1;
        e = ad + c.span;
        if (e > src_len) e = src_len;
        for (int i = ad; i < e && i < SRC_DEPTH; i++)
            if (!src_wr[i]) return 1'b0;
        return 1'b1;
    endfunction

    // Queue a command with its predicted result; repair illegal reads first
    task automatic send(t_cmd c);
        if (!reads_written(c)) begin
            if (c.cmd == vcdwd_pkg::CMD_READ) begin
                if (fill_pos > 0) c.pos = 12'($urandom_range(0, fill_pos - 1));
                else c.cmd = vcdwd_pkg::CMD_LOAD;
            end else begin
                // self copy of the window start: reads only this window's target
                c.mode = vcdwd_pkg::MODE_SELF;
                c.operand = 13'(src_len);
            end
        end
        result_q.push_back(run_command(c));
        cmd_q.push_back(c);
        n_items++;
    endtask

    function automatic t_cmd mk(logic [2:0] cmd, int pos, int data, int span, int mode,
                                int opnd);
        t_cmd c;
        c.cmd = cmd;
        c.pos = 12'(pos);
        c.data = 8'(data);
        c.span = 13'(span);
        c.mode = 4'(mode);
        c.operand = 13'(opnd);
        return c;
    endfunction

    function automatic t_cmd rand_cmd();
        t_cmd c;
        int k;
        c = t_cmd'(53'({$urandom, $urandom}));
        k = $urandom_range(0, 99);
        if (k < 2) c.cmd = vcdwd_pkg::CMD_START;
        else if (k < 17) c.cmd = vcdwd_pkg::CMD_LOAD;
        else if (k < 40) c.cmd = vcdwd_pkg::CMD_ADD;
        else if (k < 54) c.cmd = vcdwd_pkg::CMD_RUN;
        else if (k < 88) c.cmd = vcdwd_pkg::CMD_COPY;
        else if (k < 98) c.cmd = vcdwd_pkg::CMD_READ;
        else c.cmd = 3'($urandom_range(6, 7));
        // mostly short spans, a few long ones
        k = $urandom_range(0, 99);
        if (k < 85) c.span = 13'($urandom_range(0, 24));
        else if (k < 98) c.span = 13'($urandom_range(25, 200));
        else c.span = 13'($urandom_range(201, 4096));
        if (c.cmd == vcdwd_pkg::CMD_LOAD && src_len > 0 && $urandom_range(0, 3) != 0)
            c.pos = 12'($urandom_range(0, (src_len < SRC_DEPTH ? src_len : SRC_DEPTH) - 1));
        if (c.cmd == vcdwd_pkg::CMD_COPY) begin
            k = $urandom_range(0, 99);
            c.mode = k < 95 ? 4'($urandom_range(0, SAME_MODE0 + 2)) : 4'($urandom_range(9, 15));
            if ($urandom_range(0, 4) != 0) begin
                if (c.mode == vcdwd_pkg::MODE_SELF)
                    c.operand = 13'($urandom_range(0, src_len + fill_pos + 2));
                else if (c.mode == vcdwd_pkg::MODE_HERE)
                    c.operand = 13'($urandom_range(0, src_len + fill_pos + 2));
                else if (c.mode < SAME_MODE0)
                    c.operand = 13'($urandom_range(0, 8));
            end
        end
        return c;
    endfunction

    // Wait until the block has drained every queued command and result
    task automatic drain();
        while (cmd_q.size() != 0 || s_axis_tvalid || result_q.size() != 0) @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, int value);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= 13'(value);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        if (idx == vcdwd_pkg::REG_SOURCE_LENGTH) src_len = value;
        else tgt_len = value;
    endtask

    // Sender: bursts of random length separated by random gaps
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge i_clk) s_fire <= s_axis_tvalid && s_axis_tready;

    always @(negedge i_clk) begin
        t_cmd nxt;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_fire) begin
            if (gap_left > 0) begin
                gap_left--;
                s_axis_tvalid <= 1'b0;
            end else if (cmd_q.size() != 0) begin
                nxt = cmd_q.pop_front();
                s_axis_tuser <= nxt.cmd;
                s_axis_tdata <= {6'b0, nxt.operand, nxt.mode, nxt.span, nxt.data, nxt.pos};
                s_axis_tvalid <= 1'b1;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(0, 20);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left--;
                end
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: stall pattern, picked at random from four modes, changes over the run
    int rx_cnt = 0;
    int rx_mode = 0;
    always @(negedge i_clk) begin
        rx_cnt++;
        if (rx_cnt % 64 == 0) rx_mode = $urandom_range(0, 3);
        case (rx_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= $urandom_range(0, 1);
            2: m_axis_tready <= ($urandom_range(0, 3) == 0);
            default: m_axis_tready <= (rx_cnt % 8) < 5;
        endcase
    end

    // Result checker
    always @(posedge i_clk) begin
        t_result got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[36:0];
            if (result_q.size() == 0) begin
                $error("result transfer with no command outstanding: %h", m_axis_tdata);
                errors++;
            end else begin
                want = result_q.pop_front();
                st_seen[want.status]++;
                if (got.rd !== want.rd) begin
                    $error("read_data: expected %0d, actual %0d", want.rd, got.rd);
                    errors++;
                end
                if (got.addr !== want.addr) begin
                    $error("decoded_address: expected %0d, actual %0d", want.addr, got.addr);
                    errors++;
                end
                if (got.fill !== want.fill) begin
                    $error("target_fill: expected %0d, actual %0d", want.fill, got.fill);
                    errors++;
                end
                if (got.status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, got.status);
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles with no transfer while work is pending or the block is not ready
    int idle_cycles = 0;
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cmd_q.size() == 0 && !s_axis_tvalid && result_q.size() == 0 &&
             s_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("[vcdiff_window_decoder] ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Stimulus: directed opening, then windows under several register settings
    int cfg_src [6] = '{0, 4096, 300, 4096, 17, 8191};
    int cfg_tgt [6] = '{4096, 4096, 37, 0, 2000, 5461};
    initial begin
        foreach (near_addr[i]) near_addr[i] = '0;
        foreach (same_addr[i]) same_addr[i] = '0;
        near_ptr = 0;
        fill_pos = 0;
        src_len = 0;
        tgt_len = 0;
        foreach (st_seen[i]) st_seen[i] = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        while (!s_axis_tready) @(posedge i_clk);

        write_reg(vcdwd_pkg::REG_SOURCE_LENGTH, 4);
        write_reg(vcdwd_pkg::REG_TARGET_LENGTH, 40);
        send(mk(vcdwd_pkg::CMD_START, 0, 0, 0, 0, 0));
        for (int i = 0; i < 4; i++) send(mk(vcdwd_pkg::CMD_LOAD, i, 8'hA0 + i, 0, 0, 0));
        send(mk(vcdwd_pkg::CMD_LOAD, 4095, 255, 0, 0, 0));
        send(mk(vcdwd_pkg::CMD_ADD, 0, 0, 0, 0, 0));
        send(mk(vcdwd_pkg::CMD_ADD, 0, 255, 0, 0, 0));
        send(mk(vcdwd_pkg::CMD_RUN, 0, 8'h5A, 0, 0, 0));                 // zero span
        send(mk(vcdwd_pkg::CMD_RUN, 0, 8'h33, 3, 0, 0));
        send(mk(vcdwd_pkg::CMD_COPY, 0, 0, 6, vcdwd_pkg::MODE_SELF, 1));  // source into target
        send(mk(vcdwd_pkg::CMD_COPY, 0, 0, 7, vcdwd_pkg::MODE_HERE, 2));  // overlapping copy
        send(mk(vcdwd_pkg::CMD_COPY, 0, 0, 2, vcdwd_pkg::MODE_NEAR0, 1));
        send(mk(vcdwd_pkg::CMD_COPY, 0, 0, 2, vcdwd_pkg::MODE_NEAR0 + 3, 4));
        send(mk(vcdwd_pkg::CMD_COPY, 0, 0, 1, SAME_MODE0, 5));
        send(mk(vcdwd_pkg::CMD_COPY, 0, 0, 1, SAME_MODE0 + 2, 255));
        send(mk(vcdwd_pkg::CMD_COPY, 0, 0, 4, 9, 0));                     // bad mode
        send(mk(vcdwd_pkg::CMD_COPY, 0, 0, 4, 15, 8191));
        send(mk(vcdwd_pkg::CMD_COPY, 0, 0, 4, vcdwd_pkg::MODE_SELF, 8191)); // beyond written
        send(mk(vcdwd_pkg::CMD_COPY, 0, 0, 0, vcdwd_pkg::MODE_SELF, 0));  // zero span copy
        send(mk(vcdwd_pkg::CMD_READ, 3, 0, 0, 0, 0));
        send(mk(3'd7, 4095, 255, 8191, 15, 8191));                        // unknown command
        send(mk(vcdwd_pkg::CMD_RUN, 0, 8'hC3, 100, 0, 0));                // overflow
        send(mk(vcdwd_pkg::CMD_ADD, 0, 1, 0, 0, 0));
        send(mk(vcdwd_pkg::CMD_READ, 39, 0, 0, 0, 0));
        drain();

        for (int p = 0; p < 6; p++) begin
            write_reg(vcdwd_pkg::REG_SOURCE_LENGTH,
                      cfg_src[p] > 4096 ? $urandom_range(0, 4096) : cfg_src[p]);
            write_reg(vcdwd_pkg::REG_TARGET_LENGTH,
                      cfg_tgt[p] > 4096 ? $urandom_range(0, 4096) : cfg_tgt[p]);
            send(mk(vcdwd_pkg::CMD_START, 0, 0, 0, 0, 0));
            for (int i = 0; i < 300; i++) begin
                send(rand_cmd());
                // stimulus holds off until everything outstanding has come back
                if (i == 150) drain();
            end
            drain();
        end

        repeat (20) @(posedge i_clk);
        $display("Covered %0d commands over 7 register settings, results by status:", n_items);
        $display("  ok %0d, no source %0d, unwritten %0d, overflow %0d, bad mode %0d",
                 st_seen[0], st_seen[1], st_seen[2], st_seen[3], st_seen[4]);
        if (errors == 0) $display("[vcdiff_window_decoder] OK");
        else $display("[vcdiff_window_decoder] ERROR");
        $finish;
    end

endmodule
